// File: design/mbi_pkg.sv
// ----------------------------------------------------------------------------
// MACD and Bollinger indicator package
// Field widths, filter coefficients, default window depths and shared types.
// ----------------------------------------------------------------------------
package mbi_pkg;

    localparam int PRICE_W = 24;
    localparam int VOL_W   = 32;
    localparam int EMA_W   = 40;
    localparam int SIG_W   = 42;
    localparam int MACD_W  = 25;
    localparam int HIST_W  = 26;
    localparam int BAND_W  = 25;
    localparam int VAR_W   = 48;
    localparam int SD_W    = 24;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 25;

    // Smoothing factors in Q0.16, rounded to nearest.
    localparam logic [15:0] ALPHA_FAST = 16'd10082;
    localparam logic [15:0] ALPHA_SLOW = 16'd4855;
    localparam logic [15:0] ALPHA_SIG  = 16'd13107;

    localparam int DEF_SHORT_WINDOW = 9;
    localparam int DEF_LONG_WINDOW  = 20;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: design/mbi_if.sv
// ----------------------------------------------------------------------------
// MACD and Bollinger indicator stream interfaces
// Valid/ready channels for daily bars in and indicator results out.
// ----------------------------------------------------------------------------
interface mbi_bar_if import mbi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               first_item;
    logic [PRICE_W-1:0] close_price;
    logic [VOL_W-1:0]   day_volume;

    modport source (output valid, first_item, close_price, day_volume, input ready);
    modport sink   (input valid, first_item, close_price, day_volume, output ready);
endinterface

interface mbi_ind_if import mbi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [MACD_W-1:0]  macd_line;
    logic signed [MACD_W-1:0]  signal_line;
    logic signed [HIST_W-1:0]  histogram;
    logic [PRICE_W-1:0]        short_average;
    logic [PRICE_W-1:0]        long_average;
    logic [VOL_W-1:0]          volume_average;
    logic [PRICE_W-1:0]        band_middle;
    logic [BAND_W-1:0]         band_upper;
    logic signed [BAND_W-1:0]  band_lower;

    modport source (output valid, macd_line, signal_line, histogram, short_average,
                    long_average, volume_average, band_middle, band_upper, band_lower,
                    input ready);
    modport sink   (input valid, macd_line, signal_line, histogram, short_average,
                    long_average, volume_average, band_middle, band_upper, band_lower,
                    output ready);
endinterface

// File: design/macd_bollinger_indicator_stream.sv
// ----------------------------------------------------------------------------
// MACD and Bollinger indicator stream
// Per daily bar: fast, slow and signal EMAs, windowed means and bands.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake      Carries
//  i_bar    in   valid/ready    first_item, close_price, day_volume
//  o_ind    out  valid/ready    MACD, signal, histogram, means, bands
//
// Each bar runs the filter updates (skipped on the first bar of a series) and the
// window walk, then three divisions, and once the long window is full a variance
// walk and a square root search as well. The divider produces one quotient bit
// per cycle. i_bar is ready only when idle; a finished result waits in the output
// register, and only a second one waiting behind it holds up the input.
// Reset is synchronous; the window memories need no clearing.
// ----------------------------------------------------------------------------
module macd_bollinger_indicator_stream import mbi_pkg::*; #(
    parameter int SHORT_WINDOW = DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW  = DEF_LONG_WINDOW
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mbi_bar_if.sink   i_bar,
    mbi_ind_if.source o_ind
);
    localparam int HIST_DEPTH = (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
    localparam int AW     = $clog2(HIST_DEPTH);
    localparam int CW     = $clog2(HIST_DEPTH + 1);
    localparam int PSUM_W = PRICE_W + CW;
    localparam int VSUM_W = VOL_W + CW;
    localparam int SQ_W   = 2 * PRICE_W + CW;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FAST  = 5'd1;
    localparam logic [4:0] S_SLOW  = 5'd2;
    localparam logic [4:0] S_SIGM  = 5'd3;
    localparam logic [4:0] S_SIGD  = 5'd4;
    localparam logic [4:0] S_SIGU  = 5'd5;
    localparam logic [4:0] S_WALK  = 5'd6;
    localparam logic [4:0] S_DGO   = 5'd7;
    localparam logic [4:0] S_DWAIT = 5'd8;
    localparam logic [4:0] S_VAR   = 5'd9;
    localparam logic [4:0] S_SQRT  = 5'd10;
    localparam logic [4:0] S_OUT   = 5'd11;

    localparam logic [1:0] D_SHORT = 2'd0;
    localparam logic [1:0] D_LONG  = 2'd1;
    localparam logic [1:0] D_VOL   = 2'd2;

    logic [4:0]         r_state;
    logic [1:0]         r_dsel;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_newest;
    logic [CW-1:0]      r_seen;
    logic [PRICE_W-1:0] r_close;
    logic [EMA_W-1:0]   r_fast;
    logic [EMA_W-1:0]   r_slow;
    logic signed [SIG_W-1:0] r_sig;

    logic [AW-1:0]      r_ptr;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_rd_i;
    logic               r_rd_vld;
    logic               r_mv;
    logic [PSUM_W-1:0]  r_sum_s;
    logic [PSUM_W-1:0]  r_sum_l;
    logic [VSUM_W-1:0]  r_sum_v;
    logic [SQ_W-1:0]    r_sq;
    logic [PRICE_W-1:0] r_mean_s;
    logic [PRICE_W-1:0] r_mean_l;
    logic [VOL_W-1:0]   r_mean_v;
    logic [SD_W-1:0]    r_bit;
    logic               r_sq_ph;
    logic [SD_W-1:0]    r_sd;
    logic signed [PROD_W-1:0] r_prod;

    logic                      r_out_vld;
    logic signed [MACD_W-1:0]  r_o_macd;
    logic signed [MACD_W-1:0]  r_o_sig;
    logic signed [HIST_W-1:0]  r_o_hist;
    logic [PRICE_W-1:0]        r_o_short;
    logic [PRICE_W-1:0]        r_o_long;
    logic [VOL_W-1:0]          r_o_vol;
    logic [PRICE_W-1:0]        r_o_mid;
    logic [BAND_W-1:0]         r_o_up;
    logic signed [BAND_W-1:0]  r_o_lo;

    // input side
    logic               accept;
    logic [CW-1:0]      seen_base;
    logic [AW-1:0]      wr_addr;
    logic [PRICE_W-1:0] rd_price;
    logic [VOL_W-1:0]   rd_vol;
    logic [CW-1:0]      n_short;
    logic [CW-1:0]      n_long;
    logic               full;

    assign accept    = i_bar.valid && i_bar.ready;
    assign seen_base = i_bar.first_item ? '0 : r_seen;
    assign wr_addr   = i_bar.first_item ? '0 : r_head;
    assign n_short   = (r_seen < CW'(SHORT_WINDOW)) ? r_seen : CW'(SHORT_WINDOW);
    assign n_long    = (r_seen < CW'(LONG_WINDOW)) ? r_seen : CW'(LONG_WINDOW);
    assign full      = (r_seen >= CW'(LONG_WINDOW));
    assign i_bar.ready = (r_state == S_IDLE);

    mbi_ram #(.WIDTH(PRICE_W), .DEPTH(HIST_DEPTH)) u_price_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_bar.close_price),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_price)
    );

    mbi_ram #(.WIDTH(VOL_W), .DEPTH(HIST_DEPTH)) u_volume_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_bar.day_volume),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_vol)
    );

    // shared divider
    logic              div_start;
    logic [VSUM_W-1:0] div_num;
    logic [CW-1:0]     div_den;
    logic [VSUM_W-1:0] div_quot;
    t_div_status       div_stat;

    assign div_start = (r_state == S_DGO);

    always_comb begin
        case (r_dsel)
            D_SHORT: begin
                div_num = VSUM_W'(r_sum_s);
                div_den = n_short;
            end
            D_LONG: begin
                div_num = VSUM_W'(r_sum_l);
                div_den = n_long;
            end
            default: begin
                div_num = r_sum_v;
                div_den = n_long;
            end
        endcase
    end

    mbi_divider #(.NUM_W(VSUM_W), .DEN_W(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_A_W-1:0] x_ext;
    logic signed [MUL_A_W-1:0] macd_full;
    logic [PRICE_W-1:0]        dev;
    logic [SD_W-1:0]           sd_try;

    assign x_ext     = signed'({2'b00, r_close, 16'h0000});
    assign macd_full = signed'({2'b00, r_fast}) - signed'({2'b00, r_slow});
    assign dev       = (rd_price >= r_mean_l) ? rd_price - r_mean_l : r_mean_l - rd_price;
    assign sd_try    = r_sd | r_bit;

    always_comb begin
        case (r_state)
            S_FAST: begin
                mul_a = x_ext - signed'({2'b00, r_fast});
                mul_b = signed'({9'd0, ALPHA_FAST});
            end
            S_SLOW: begin
                mul_a = x_ext - signed'({2'b00, r_slow});
                mul_b = signed'({9'd0, ALPHA_SLOW});
            end
            S_SIGD: begin
                mul_a = macd_full - r_sig;
                mul_b = signed'({9'd0, ALPHA_SIG});
            end
            S_SQRT: begin
                mul_a = signed'({(MUL_A_W - SD_W)'(0), sd_try});
                mul_b = signed'({1'b0, sd_try});
            end
            default: begin
                mul_a = signed'({(MUL_A_W - PRICE_W)'(0), dev});
                mul_b = signed'({1'b0, dev});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // The filter step is floor(alpha * (x - e) / 65536), added to the state.
    logic signed [EMA_W+2:0] ema_step;
    logic signed [EMA_W+2:0] fast_sum;
    logic signed [EMA_W+2:0] slow_sum;
    logic signed [SIG_W-1:0] sig_step;

    assign ema_step = r_prod[EMA_W+18:16];
    assign fast_sum = signed'({3'b000, r_fast}) + ema_step;
    assign slow_sum = signed'({3'b000, r_slow}) + ema_step;
    assign sig_step = r_prod[SIG_W+15:16];

    // The deviation is the largest root whose square, scaled by the window
    // length, still fits under the summed squares; that equals the square root
    // of the truncated variance.
    logic [SQ_W-1:0]          sq_scaled;
    logic [AW-1:0]            ptr_prev;
    logic signed [MACD_W-1:0] macd_q;
    logic signed [HIST_W-1:0] sig_q;
    logic [BAND_W:0]          up_sum;
    logic signed [BAND_W+1:0] lo_diff;

    assign sq_scaled = SQ_W'(r_prod[2*SD_W-1:0]) * SQ_W'(LONG_WINDOW);
    assign ptr_prev = (r_ptr == '0) ? AW'(HIST_DEPTH - 1) : r_ptr - 1'b1;
    assign macd_q   = macd_full[MACD_W+15:16];
    assign sig_q    = r_sig[HIST_W+15:16];
    assign up_sum   = {2'b00, r_mean_l} + {1'b0, r_sd, 1'b0};
    assign lo_diff  = signed'({3'b000, r_mean_l}) - signed'({2'b00, r_sd, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dsel    <= D_SHORT;
            r_head    <= '0;
            r_seen    <= '0;
            r_fast    <= '0;
            r_slow    <= '0;
            r_sig     <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_mv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ind.valid && o_ind.ready && r_state != S_OUT) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_close  <= i_bar.close_price;
                        r_newest <= wr_addr;
                        r_ptr    <= wr_addr;
                        r_head   <= (wr_addr == AW'(HIST_DEPTH - 1)) ? '0 : wr_addr + 1'b1;
                        r_seen   <= (seen_base == CW'(HIST_DEPTH)) ? seen_base
                                                                   : seen_base + 1'b1;
                        r_cnt    <= '0;
                        r_sum_s  <= '0;
                        r_sum_l  <= '0;
                        r_sum_v  <= '0;
                        r_sd     <= '0;
                        if (seen_base == '0) begin
                            // New series: both filters start at the close.
                            r_fast  <= {i_bar.close_price, 16'h0000};
                            r_slow  <= {i_bar.close_price, 16'h0000};
                            r_sig   <= '0;
                            r_state <= S_WALK;
                        end else begin
                            r_state <= S_FAST;
                        end
                    end
                end
                S_FAST: r_state <= S_SLOW;
                S_SLOW: begin
                    r_fast  <= fast_sum[EMA_W-1:0];
                    r_state <= S_SIGM;
                end
                S_SIGM: begin
                    r_slow  <= slow_sum[EMA_W-1:0];
                    r_state <= S_SIGD;
                end
                S_SIGD: r_state <= S_SIGU;
                S_SIGU: begin
                    r_sig   <= r_sig + sig_step;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_rd_vld <= (r_cnt < r_seen);
                    r_rd_i   <= r_cnt;
                    if (r_cnt < r_seen) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_ptr <= ptr_prev;
                    end
                    if (r_rd_vld) begin
                        if (r_rd_i < n_short) begin
                            r_sum_s <= r_sum_s + PSUM_W'(rd_price);
                        end
                        if (r_rd_i < n_long) begin
                            r_sum_l <= r_sum_l + PSUM_W'(rd_price);
                            r_sum_v <= r_sum_v + VSUM_W'(rd_vol);
                        end
                    end
                    if (r_cnt == r_seen && !r_rd_vld) begin
                        r_dsel  <= D_SHORT;
                        r_state <= S_DGO;
                    end
                end
                S_DGO: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (div_stat.done) begin
                        case (r_dsel)
                            D_SHORT: begin
                                r_mean_s <= div_quot[PRICE_W-1:0];
                                r_dsel   <= D_LONG;
                                r_state  <= S_DGO;
                            end
                            D_LONG: begin
                                r_mean_l <= div_quot[PRICE_W-1:0];
                                r_dsel   <= D_VOL;
                                r_state  <= S_DGO;
                            end
                            default: begin
                                r_mean_v <= div_quot[VOL_W-1:0];
                                r_cnt    <= '0;
                                r_ptr    <= r_newest;
                                r_sq     <= '0;
                                r_state  <= full ? S_VAR : S_OUT;
                            end
                        endcase
                    end
                end
                S_VAR: begin
                    // read, then square the deviation, then accumulate
                    r_rd_vld <= (r_cnt < CW'(LONG_WINDOW));
                    r_mv     <= r_rd_vld;
                    if (r_cnt < CW'(LONG_WINDOW)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_ptr <= ptr_prev;
                    end
                    if (r_mv) begin
                        r_sq <= r_sq + SQ_W'(r_prod[2*PRICE_W-1:0]);
                    end
                    if (r_cnt == CW'(LONG_WINDOW) && !r_rd_vld && !r_mv) begin
                        r_sd    <= '0;
                        r_bit   <= {1'b1, (SD_W - 1)'(0)};
                        r_sq_ph <= 1'b0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // The first phase squares the trial root, the second keeps the bit if it fits.
                    r_sq_ph <= !r_sq_ph;
                    if (r_sq_ph) begin
                        if (sq_scaled <= r_sq) begin
                            r_sd <= sd_try;
                        end
                        r_bit <= r_bit >> 1;
                        if (r_bit == SD_W'(1)) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || o_ind.ready) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_vld || o_ind.ready)) begin
            r_o_macd  <= macd_q;
            r_o_sig   <= sig_q[MACD_W-1:0];
            r_o_hist  <= HIST_W'(macd_q) - sig_q;
            r_o_short <= r_mean_s;
            r_o_long  <= r_mean_l;
            r_o_vol   <= r_mean_v;
            if (full) begin
                r_o_mid <= r_mean_l;
                r_o_up  <= up_sum[BAND_W] ? {BAND_W{1'b1}} : up_sum[BAND_W-1:0];
                r_o_lo  <= (lo_diff < -(BAND_W + 2)'(1 << (BAND_W - 1)))
                         ? signed'({1'b1, (BAND_W - 1)'(0)}) : lo_diff[BAND_W-1:0];
            end else begin
                r_o_mid <= r_close;
                r_o_up  <= {1'b0, r_close};
                r_o_lo  <= signed'({1'b0, r_close});
            end
        end
    end

    assign o_ind.valid          = r_out_vld;
    assign o_ind.macd_line      = r_o_macd;
    assign o_ind.signal_line    = r_o_sig;
    assign o_ind.histogram      = r_o_hist;
    assign o_ind.short_average  = r_o_short;
    assign o_ind.long_average   = r_o_long;
    assign o_ind.volume_average = r_o_vol;
    assign o_ind.band_middle    = r_o_mid;
    assign o_ind.band_upper     = r_o_up;
    assign o_ind.band_lower     = r_o_lo;
endmodule

// File: design/mbi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: design/mbi_divider.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbi_divider import mbi_pkg::*; #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot,
    output t_div_status      o_stat
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

// File: design/mbi_checker.sv
// ----------------------------------------------------------------------------
// MACD and Bollinger indicator checker
// Port-level checks of the handshakes and the one-bar-at-a-time sequencing.
// ----------------------------------------------------------------------------
module mbi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    // A result offered must stay offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before transaction completed");

    // Once a bar is taken the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input still ready after a transaction");

    // No result can appear in the cycle after a bar is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early");

    // A new result is only loaded while the input side is busy.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result loaded while idle");
endmodule

bind macd_bollinger_indicator_stream mbi_checker u_mbi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_bar.valid),
    .i_in_ready  (i_bar.ready),
    .i_out_valid (o_ind.valid),
    .i_out_ready (o_ind.ready)
);
